### rtl/c8_pkg.sv
// shared types, constants and helper functions for the chip-8 instruction core
// no dependencies; used by c8_core and chip8_instruction_core_top
package c8_pkg;

	// machine geometry
	localparam int MEM_BYTES    = 4096;
	localparam int MEM_AW       = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH  = 16;
	localparam int SP_W         = $clog2(STACK_DEPTH);
	localparam int SCR_W        = 64;
	localparam int SCR_H        = 32;
	localparam int SCR_XW       = $clog2(SCR_W);
	localparam int SCR_YW       = $clog2(SCR_H);
	localparam int FRAME_PIXELS = SCR_W * SCR_H;
	localparam int FR_AW        = $clog2(FRAME_PIXELS);
	localparam int KEY_COUNT    = 16;
	localparam int PC_W         = 12;
	localparam int CNT_W        = (FR_AW > 4) ? FR_AW : 4;
	localparam int CLR_W        = (MEM_AW > FR_AW) ? MEM_AW : FR_AW;

	localparam logic [PC_W-1:0] START_RESET = 12'h200;

	// command codes
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_PIXEL = 3'd2;
	localparam logic [2:0] CMD_EXEC  = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	// opcode groups (top nibble)
	localparam logic [3:0] OPG_SYS    = 4'h0;
	localparam logic [3:0] OPG_JP     = 4'h1;
	localparam logic [3:0] OPG_CALL   = 4'h2;
	localparam logic [3:0] OPG_SE_I   = 4'h3;
	localparam logic [3:0] OPG_SNE_I  = 4'h4;
	localparam logic [3:0] OPG_SE_R   = 4'h5;
	localparam logic [3:0] OPG_LD_I   = 4'h6;
	localparam logic [3:0] OPG_ADD_I  = 4'h7;
	localparam logic [3:0] OPG_ALU    = 4'h8;
	localparam logic [3:0] OPG_SNE_R  = 4'h9;
	localparam logic [3:0] OPG_LD_IDX = 4'hA;
	localparam logic [3:0] OPG_JP_V0  = 4'hB;
	localparam logic [3:0] OPG_RND    = 4'hC;
	localparam logic [3:0] OPG_DRW    = 4'hD;
	localparam logic [3:0] OPG_KEY    = 4'hE;
	localparam logic [3:0] OPG_MISC   = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// alu function codes (low nibble of 8xyn)
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// low-byte function codes of ex and fx groups
	localparam logic [7:0] FN_SKP      = 8'h9E;
	localparam logic [7:0] FN_SKNP     = 8'hA1;
	localparam logic [7:0] FN_LD_DT    = 8'h07;
	localparam logic [7:0] FN_WAIT_KEY = 8'h0A;
	localparam logic [7:0] FN_SET_DT   = 8'h15;
	localparam logic [7:0] FN_SET_ST   = 8'h18;
	localparam logic [7:0] FN_ADD_IDX  = 8'h1E;
	localparam logic [7:0] FN_FONT     = 8'h29;
	localparam logic [7:0] FN_BCD      = 8'h33;
	localparam logic [7:0] FN_STORE    = 8'h55;
	localparam logic [7:0] FN_LOAD     = 8'h65;

	localparam logic [7:0] FONT_BYTES = 8'd5;
	localparam logic [1:0] BCD_LAST   = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MWR,
		ST_MRD,
		ST_MWAIT,
		ST_PRD,
		ST_PWAIT,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_FETCH_END,
		ST_READ_VY,
		ST_EXEC,
		ST_CLS,
		ST_CLS_END,
		ST_DRAW_ROW,
		ST_DRAW_BITS,
		ST_DRAW_PIX,
		ST_DRAW_WR,
		ST_DRAW_FIN,
		ST_BCD,
		ST_STORE,
		ST_LOAD,
		ST_LOAD_END,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [11:0] address;
		logic [7:0]  data;
		logic [15:0] keys;
		logic [7:0]  random_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]      read_value;
		logic [PC_W-1:0] program_counter;
		logic            sound_active;
		logic            waiting_for_key;
		logic            screen_changed;
	} result_t;

	// one decimal digit of an 8-bit value: 0 hundreds, 1 tens, else ones
	function automatic logic [7:0] bcd_digit(input logic [7:0] val, input logic [1:0] sel);
		logic [1:0]  hund;
		logic [7:0]  rem8;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		if (val >= 8'd200) begin
			hund = 2'd2;
			rem8 = val - 8'd200;
		end else if (val >= 8'd100) begin
			hund = 2'd1;
			rem8 = val - 8'd100;
		end else begin
			hund = 2'd0;
			rem8 = val;
		end
		rem  = rem8[6:0];
		// divide by ten through reciprocal, exact for every 7-bit remainder
		prod = 15'(rem) * 15'd205;
		tens = prod[14:11];
		ones = rem - 7'(tens) * 7'd10;
		case (sel)
			2'd0:    bcd_digit = {6'd0, hund};
			2'd1:    bcd_digit = {4'd0, tens};
			default: bcd_digit = {4'd0, ones[3:0]};
		endcase
	endfunction

	// lowest pressed key: {found, index}
	function automatic logic [4:0] first_key(input logic [KEY_COUNT-1:0] k);
		logic [4:0] r;
		r = 5'd0;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (k[i]) begin
				r = {1'b1, 4'(i)};
			end
		end
		return r;
	endfunction

endpackage

### rtl/c8_ram.sv
// generic single-port synchronous ram, read-first, registered read
// no dependencies
module c8_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### rtl/c8_core.sv
// chip-8 sequencer: registers, instruction decode and memory/frame access
// depends on c8_pkg and c8_ram
module c8_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  c8_pkg::item_t            item,
	input  logic                     item_valid,
	output logic                     item_busy,
	output c8_pkg::result_t          res,
	output logic                     res_valid,
	input  logic                     res_take,
	input  logic                     cfg_we,
	input  logic [c8_pkg::PC_W-1:0]  cfg_pc
);

	c8_pkg::state_t state_q, state_nxt;

	// item and architectural registers
	c8_pkg::item_t               item_q;
	logic [c8_pkg::PC_W-1:0]     pc_q;
	logic [15:0]                 i_q;
	logic [c8_pkg::SP_W-1:0]     sp_q;
	logic [7:0]                  dt_q;
	logic [7:0]                  st_q;
	logic [7:0]                  v_q [16];
	logic [c8_pkg::PC_W-1:0]     stack_q [c8_pkg::STACK_DEPTH];

	// work registers
	logic [15:0]                 op_q;
	logic [7:0]                  vx_q;
	logic [7:0]                  vy_q;
	logic [c8_pkg::CNT_W-1:0]    cnt_q;
	logic [c8_pkg::CLR_W-1:0]    clr_q;
	logic [3:0]                  row_q;
	logic [2:0]                  col_q;
	logic [7:0]                  bits_q;
	logic                        hit_q;
	logic [7:0]                  rv_q;
	logic                        wait_q;
	logic                        chg_q;
	logic                        chk_s1;
	logic                        ld_s1;
	logic [3:0]                  ld_idx_s1;

	// memory ports
	logic                        mem_we;
	logic [c8_pkg::MEM_AW-1:0]   mem_a;
	logic [7:0]                  mem_wd;
	logic [7:0]                  mem_rd;
	logic                        fr_we;
	logic [c8_pkg::FR_AW-1:0]    fr_a;
	logic                        fr_wd;
	logic                        fr_rd;

	// decode helpers
	logic [3:0]                  grp;
	logic [3:0]                  op_x;
	logic [3:0]                  op_n;
	logic [7:0]                  op_nn;
	logic [11:0]                 op_nnn;
	logic [3:0]                  v_ra;
	logic [7:0]                  v_rd;
	logic                        pix_bit;
	logic                        col_last;
	logic                        row_last;
	logic [c8_pkg::SCR_XW-1:0]   px;
	logic [c8_pkg::SCR_YW-1:0]   py;
	logic [c8_pkg::MEM_AW-1:0]   i_cnt_a;
	logic [4:0]                  key_hit;
	logic [8:0]                  add9;

	// register write controls
	logic                        v_we;
	logic [3:0]                  v_wa;
	logic [7:0]                  v_wd;
	logic                        vf_we;
	logic [7:0]                  vf_wd;
	logic                        pc_we;
	logic [c8_pkg::PC_W-1:0]     pc_wd;
	logic                        i_we;
	logic [15:0]                 i_wd;
	logic                        push;
	logic                        pop;
	logic                        dt_we;
	logic                        st_we;
	logic                        wait_set;

	assign grp      = op_q[15:12];
	assign op_x     = op_q[11:8];
	assign op_n     = op_q[3:0];
	assign op_nn    = op_q[7:0];
	assign op_nnn   = op_q[11:0];
	assign v_rd     = v_q[v_ra];
	assign pix_bit  = bits_q[3'd7 - col_q];
	assign col_last = (col_q == 3'd7);
	assign row_last = (({1'b0, row_q} + 5'd1) == {1'b0, op_n});
	assign px       = c8_pkg::SCR_XW'(vx_q + 8'(col_q));
	assign py       = c8_pkg::SCR_YW'(vy_q + 8'(row_q));
	assign i_cnt_a  = c8_pkg::MEM_AW'(32'(i_q) + 32'(cnt_q));
	assign key_hit  = c8_pkg::first_key(item_q.keys);
	assign add9     = {1'b0, vx_q} + {1'b0, vy_q};

	c8_ram #(.DEPTH(c8_pkg::MEM_BYTES), .WIDTH(8)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_a),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	c8_ram #(.DEPTH(c8_pkg::FRAME_PIXELS), .WIDTH(1)) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.addr  (fr_a),
		.wdata (fr_wd),
		.rdata (fr_rd)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			c8_pkg::ST_CLEAR: begin
				if (&clr_q) state_nxt = c8_pkg::ST_IDLE;
			end
			c8_pkg::ST_IDLE: begin
				if (item_valid) begin
					case (item.command)
						c8_pkg::CMD_WRITE: state_nxt = c8_pkg::ST_MWR;
						c8_pkg::CMD_READ:  state_nxt = c8_pkg::ST_MRD;
						c8_pkg::CMD_PIXEL: state_nxt = c8_pkg::ST_PRD;
						c8_pkg::CMD_EXEC:  state_nxt = c8_pkg::ST_FETCH_HI;
						default:           state_nxt = c8_pkg::ST_DONE;
					endcase
				end
			end
			c8_pkg::ST_MWR:       state_nxt = c8_pkg::ST_DONE;
			c8_pkg::ST_MRD:       state_nxt = c8_pkg::ST_MWAIT;
			c8_pkg::ST_MWAIT:     state_nxt = c8_pkg::ST_DONE;
			c8_pkg::ST_PRD: begin
				if (32'(item_q.address) < c8_pkg::FRAME_PIXELS) state_nxt = c8_pkg::ST_PWAIT;
				else state_nxt = c8_pkg::ST_DONE;
			end
			c8_pkg::ST_PWAIT:     state_nxt = c8_pkg::ST_DONE;
			c8_pkg::ST_FETCH_HI:  state_nxt = c8_pkg::ST_FETCH_LO;
			c8_pkg::ST_FETCH_LO:  state_nxt = c8_pkg::ST_FETCH_END;
			c8_pkg::ST_FETCH_END: state_nxt = c8_pkg::ST_READ_VY;
			c8_pkg::ST_READ_VY:   state_nxt = c8_pkg::ST_EXEC;
			c8_pkg::ST_EXEC: begin
				state_nxt = c8_pkg::ST_DONE;
				if (op_q == c8_pkg::OP_CLS) begin
					state_nxt = c8_pkg::ST_CLS;
				end else if (grp == c8_pkg::OPG_DRW) begin
					state_nxt = (op_n == 4'd0) ? c8_pkg::ST_DRAW_FIN : c8_pkg::ST_DRAW_ROW;
				end else if (grp == c8_pkg::OPG_MISC) begin
					if (op_nn == c8_pkg::FN_BCD) state_nxt = c8_pkg::ST_BCD;
					else if (op_nn == c8_pkg::FN_STORE) state_nxt = c8_pkg::ST_STORE;
					else if (op_nn == c8_pkg::FN_LOAD) state_nxt = c8_pkg::ST_LOAD;
				end
			end
			c8_pkg::ST_CLS: begin
				if (cnt_q == c8_pkg::CNT_W'(c8_pkg::FRAME_PIXELS - 1))
					state_nxt = c8_pkg::ST_CLS_END;
			end
			c8_pkg::ST_CLS_END:   state_nxt = c8_pkg::ST_DONE;
			c8_pkg::ST_DRAW_ROW:  state_nxt = c8_pkg::ST_DRAW_BITS;
			c8_pkg::ST_DRAW_BITS: state_nxt = c8_pkg::ST_DRAW_PIX;
			c8_pkg::ST_DRAW_PIX: begin
				if (pix_bit) state_nxt = c8_pkg::ST_DRAW_WR;
				else if (col_last)
					state_nxt = row_last ? c8_pkg::ST_DRAW_FIN : c8_pkg::ST_DRAW_ROW;
			end
			c8_pkg::ST_DRAW_WR: begin
				if (!col_last) state_nxt = c8_pkg::ST_DRAW_PIX;
				else state_nxt = row_last ? c8_pkg::ST_DRAW_FIN : c8_pkg::ST_DRAW_ROW;
			end
			c8_pkg::ST_DRAW_FIN:  state_nxt = c8_pkg::ST_DONE;
			c8_pkg::ST_BCD: begin
				if (cnt_q[1:0] == c8_pkg::BCD_LAST) state_nxt = c8_pkg::ST_DONE;
			end
			c8_pkg::ST_STORE: begin
				if (cnt_q[3:0] == op_x) state_nxt = c8_pkg::ST_DONE;
			end
			c8_pkg::ST_LOAD: begin
				if (cnt_q[3:0] == op_x) state_nxt = c8_pkg::ST_LOAD_END;
			end
			c8_pkg::ST_LOAD_END:  state_nxt = c8_pkg::ST_DONE;
			c8_pkg::ST_DONE: begin
				if (res_take) state_nxt = c8_pkg::ST_IDLE;
			end
			default:              state_nxt = c8_pkg::ST_IDLE;
		endcase
	end

	// memory, frame and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_a     = c8_pkg::MEM_AW'(item_q.address);
		mem_wd    = 8'd0;
		fr_we     = 1'b0;
		fr_a      = {py, px};
		fr_wd     = 1'b0;
		v_ra      = op_x;
		item_busy = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			c8_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_a  = c8_pkg::MEM_AW'(clr_q);
				fr_we  = 1'b1;
				fr_a   = c8_pkg::FR_AW'(clr_q);
			end
			c8_pkg::ST_IDLE:      item_busy = 1'b0;
			c8_pkg::ST_MWR: begin
				mem_we = 1'b1;
				mem_wd = item_q.data;
			end
			c8_pkg::ST_PRD:       fr_a = c8_pkg::FR_AW'(item_q.address);
			c8_pkg::ST_FETCH_HI:  mem_a = c8_pkg::MEM_AW'(pc_q);
			c8_pkg::ST_FETCH_LO:  mem_a = c8_pkg::MEM_AW'(32'(pc_q) + 32'd1);
			c8_pkg::ST_READ_VY:   v_ra = op_q[7:4];
			c8_pkg::ST_CLS: begin
				fr_we = 1'b1;
				fr_a  = c8_pkg::FR_AW'(cnt_q);
			end
			c8_pkg::ST_DRAW_ROW:  mem_a = c8_pkg::MEM_AW'(32'(i_q) + 32'(row_q));
			c8_pkg::ST_DRAW_WR: begin
				fr_we = 1'b1;
				fr_wd = ~fr_rd;
			end
			c8_pkg::ST_BCD: begin
				mem_we = 1'b1;
				mem_a  = i_cnt_a;
				mem_wd = c8_pkg::bcd_digit(vx_q, cnt_q[1:0]);
			end
			c8_pkg::ST_STORE: begin
				v_ra   = cnt_q[3:0];
				mem_we = 1'b1;
				mem_a  = i_cnt_a;
				mem_wd = v_rd;
			end
			c8_pkg::ST_LOAD:      mem_a = i_cnt_a;
			c8_pkg::ST_DONE:      res_valid = 1'b1;
			default: ;
		endcase
	end

	// instruction effects on the register file
	always_comb begin
		v_we     = 1'b0;
		v_wa     = op_x;
		v_wd     = 8'd0;
		vf_we    = 1'b0;
		vf_wd    = 8'd0;
		pc_we    = 1'b0;
		pc_wd    = pc_q + c8_pkg::PC_W'(2);
		i_we     = 1'b0;
		i_wd     = i_q;
		push     = 1'b0;
		pop      = 1'b0;
		dt_we    = 1'b0;
		st_we    = 1'b0;
		wait_set = 1'b0;
		if (ld_s1) begin
			v_we = 1'b1;
			v_wa = ld_idx_s1;
			v_wd = mem_rd;
		end
		if (state_q == c8_pkg::ST_DRAW_FIN) begin
			vf_we = 1'b1;
			vf_wd = {7'd0, hit_q};
		end
		if (state_q == c8_pkg::ST_EXEC) begin
			unique case (grp)
				c8_pkg::OPG_SYS: begin
					if (op_q == c8_pkg::OP_RET) begin
						pop   = 1'b1;
						pc_we = 1'b1;
						pc_wd = stack_q[sp_q - c8_pkg::SP_W'(1)];
					end
				end
				c8_pkg::OPG_JP: begin
					pc_we = 1'b1;
					pc_wd = op_nnn;
				end
				c8_pkg::OPG_CALL: begin
					push  = 1'b1;
					pc_we = 1'b1;
					pc_wd = op_nnn;
				end
				c8_pkg::OPG_SE_I:   pc_we = (vx_q == op_nn);
				c8_pkg::OPG_SNE_I:  pc_we = (vx_q != op_nn);
				c8_pkg::OPG_SE_R:   pc_we = (vx_q == vy_q);
				c8_pkg::OPG_SNE_R:  pc_we = (vx_q != vy_q);
				c8_pkg::OPG_LD_I: begin
					v_we = 1'b1;
					v_wd = op_nn;
				end
				c8_pkg::OPG_ADD_I: begin
					v_we = 1'b1;
					v_wd = vx_q + op_nn;
				end
				c8_pkg::OPG_ALU: begin
					case (op_n)
						c8_pkg::ALU_MOV: begin
							v_we = 1'b1;
							v_wd = vy_q;
						end
						c8_pkg::ALU_OR: begin
							v_we = 1'b1;
							v_wd = vx_q | vy_q;
						end
						c8_pkg::ALU_AND: begin
							v_we = 1'b1;
							v_wd = vx_q & vy_q;
						end
						c8_pkg::ALU_XOR: begin
							v_we = 1'b1;
							v_wd = vx_q ^ vy_q;
						end
						c8_pkg::ALU_ADD: begin
							v_we  = 1'b1;
							v_wd  = add9[7:0];
							vf_we = 1'b1;
							vf_wd = {7'd0, add9[8]};
						end
						c8_pkg::ALU_SUB: begin
							v_we  = 1'b1;
							v_wd  = vx_q - vy_q;
							vf_we = 1'b1;
							vf_wd = {7'd0, vx_q >= vy_q};
						end
						c8_pkg::ALU_SHR: begin
							v_we  = 1'b1;
							v_wd  = {1'b0, vx_q[7:1]};
							vf_we = 1'b1;
							vf_wd = {7'd0, vx_q[0]};
						end
						c8_pkg::ALU_SUBN: begin
							v_we  = 1'b1;
							v_wd  = vy_q - vx_q;
							vf_we = 1'b1;
							vf_wd = {7'd0, vy_q >= vx_q};
						end
						c8_pkg::ALU_SHL: begin
							v_we  = 1'b1;
							v_wd  = {vx_q[6:0], 1'b0};
							vf_we = 1'b1;
							vf_wd = {7'd0, vx_q[7]};
						end
						default: ;
					endcase
				end
				c8_pkg::OPG_LD_IDX: begin
					i_we = 1'b1;
					i_wd = {4'd0, op_nnn};
				end
				c8_pkg::OPG_JP_V0: begin
					pc_we = 1'b1;
					pc_wd = c8_pkg::PC_W'(12'(v_q[0]) + op_nnn);
				end
				c8_pkg::OPG_RND: begin
					v_we = 1'b1;
					v_wd = item_q.random_byte & op_nn;
				end
				c8_pkg::OPG_DRW: ;
				c8_pkg::OPG_KEY: begin
					if (op_nn == c8_pkg::FN_SKP) pc_we = item_q.keys[vx_q[3:0]];
					else if (op_nn == c8_pkg::FN_SKNP) pc_we = !item_q.keys[vx_q[3:0]];
				end
				c8_pkg::OPG_MISC: begin
					case (op_nn)
						c8_pkg::FN_LD_DT: begin
							v_we = 1'b1;
							v_wd = dt_q;
						end
						c8_pkg::FN_WAIT_KEY: begin
							if (key_hit[4]) begin
								v_we = 1'b1;
								v_wd = {4'd0, key_hit[3:0]};
							end else begin
								pc_we    = 1'b1;
								pc_wd    = pc_q - c8_pkg::PC_W'(2);
								wait_set = 1'b1;
							end
						end
						c8_pkg::FN_SET_DT:  dt_we = 1'b1;
						c8_pkg::FN_SET_ST:  st_we = 1'b1;
						c8_pkg::FN_ADD_IDX: begin
							i_we = 1'b1;
							i_wd = i_q + {8'd0, vx_q};
						end
						c8_pkg::FN_FONT: begin
							i_we = 1'b1;
							i_wd = 16'({4'd0, vx_q[3:0]} * c8_pkg::FONT_BYTES);
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c8_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// architectural and work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= c8_pkg::START_RESET;
			i_q       <= 16'd0;
			sp_q      <= '0;
			dt_q      <= 8'd0;
			st_q      <= 8'd0;
			clr_q     <= '0;
			cnt_q     <= '0;
			row_q     <= 4'd0;
			col_q     <= 3'd0;
			vx_q      <= 8'd0;
			vy_q      <= 8'd0;
			bits_q    <= 8'd0;
			hit_q     <= 1'b0;
			rv_q      <= 8'd0;
			wait_q    <= 1'b0;
			chg_q     <= 1'b0;
			chk_s1    <= 1'b0;
			ld_s1     <= 1'b0;
			ld_idx_s1 <= 4'd0;
			for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
			for (int k = 0; k < c8_pkg::STACK_DEPTH; k++) stack_q[k] <= '0;
		end else begin
			chk_s1    <= (state_q == c8_pkg::ST_CLS);
			ld_s1     <= (state_q == c8_pkg::ST_LOAD);
			ld_idx_s1 <= cnt_q[3:0];

			if (state_q == c8_pkg::ST_CLEAR) clr_q <= clr_q + c8_pkg::CLR_W'(1);

			// item transfer into the core
			if (state_q == c8_pkg::ST_IDLE && item_valid) begin
				rv_q   <= 8'd0;
				wait_q <= 1'b0;
				chg_q  <= 1'b0;
				if (item.command == c8_pkg::CMD_TICK) begin
					if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
					if (st_q != 8'd0) st_q <= st_q - 8'd1;
				end
			end

			if (state_q == c8_pkg::ST_MWAIT) rv_q <= mem_rd;
			if (state_q == c8_pkg::ST_PWAIT) rv_q <= {7'd0, fr_rd};
			if (state_q == c8_pkg::ST_FETCH_END) begin
				vx_q <= v_rd;
				pc_q <= pc_q + c8_pkg::PC_W'(2);
			end
			if (state_q == c8_pkg::ST_READ_VY) vy_q <= v_rd;

			// counters of the multi-cycle instructions
			if (state_q == c8_pkg::ST_EXEC) begin
				cnt_q <= '0;
				row_q <= 4'd0;
				col_q <= 3'd0;
				hit_q <= 1'b0;
			end
			if (state_q == c8_pkg::ST_CLS || state_q == c8_pkg::ST_BCD ||
				state_q == c8_pkg::ST_STORE || state_q == c8_pkg::ST_LOAD)
				cnt_q <= cnt_q + c8_pkg::CNT_W'(1);

			// clear check in the cycle after the frame read
			if (chk_s1 && fr_rd) chg_q <= 1'b1;

			// sprite walk
			if (state_q == c8_pkg::ST_DRAW_BITS) begin
				bits_q <= mem_rd;
				col_q  <= 3'd0;
			end
			if ((state_q == c8_pkg::ST_DRAW_PIX && !pix_bit) ||
				state_q == c8_pkg::ST_DRAW_WR) begin
				col_q <= col_q + 3'd1;
				if (col_last) row_q <= row_q + 4'd1;
			end
			if (state_q == c8_pkg::ST_DRAW_WR) begin
				chg_q <= 1'b1;
				if (fr_rd) hit_q <= 1'b1;
			end

			// register file writes, flag last
			if (v_we) v_q[v_wa] <= v_wd;
			if (vf_we) v_q[15] <= vf_wd;
			if (pc_we) pc_q <= pc_wd;
			if (i_we) i_q <= i_wd;
			if (push) begin
				stack_q[sp_q] <= pc_q;
				sp_q          <= sp_q + c8_pkg::SP_W'(1);
			end
			if (pop) sp_q <= sp_q - c8_pkg::SP_W'(1);
			if (dt_we) dt_q <= vx_q;
			if (st_we) st_q <= vx_q;
			if (wait_set) wait_q <= 1'b1;

			if (cfg_we) pc_q <= cfg_pc;
		end
	end

	// item and opcode capture, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == c8_pkg::ST_IDLE && item_valid) item_q <= item;
		if (state_q == c8_pkg::ST_FETCH_LO) op_q[15:8] <= mem_rd;
		if (state_q == c8_pkg::ST_FETCH_END) op_q[7:0] <= mem_rd;
	end

	assign res.read_value      = rv_q;
	assign res.program_counter = pc_q;
	assign res.sound_active    = (st_q != 8'd0);
	assign res.waiting_for_key = wait_q;
	assign res.screen_changed  = chg_q;

endmodule

### rtl/chip8_instruction_core_top.sv
// chip-8 instruction core top level: channel handshakes and result register
// depends on c8_pkg and c8_core
//
// usage:
// input channel (in_valid/in_stall) transfers one command item: memory write,
// memory read, pixel read, execute one instruction or timer tick. the output
// channel (out_valid/out_stall) returns exactly one result per item, in order.
// items are handled one at a time; in_stall is high while an item is at work.
// the frame clear and sprite walk are bounded by the single frame memory port.
// the result waits in an output register; a stalled receiver holds it and
// the core finishes its next item but then holds it until the register frees.
// config channel (cfg_valid/cfg_ready) writes start_address, which is loaded
// into the program counter at once; cfg_ready is always high.
// after reset the core clears main memory and frame with in_stall high; the
// program counter starts at 0x200.
module chip8_instruction_core_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              command,
	input  logic [11:0]             address,
	input  logic [7:0]              data,
	input  logic [15:0]             keys,
	input  logic [7:0]              random_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              read_value,
	output logic [11:0]             program_counter,
	output logic                    sound_active,
	output logic                    waiting_for_key,
	output logic                    screen_changed,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [11:0]             start_address
);

	c8_pkg::item_t   item;
	c8_pkg::result_t res;
	c8_pkg::result_t out_q;
	logic            out_valid_q;
	logic            res_valid;
	logic            res_take;
	logic            busy;

	assign item.command     = command;
	assign item.address     = address;
	assign item.data        = data;
	assign item.keys        = keys;
	assign item.random_byte = random_byte;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign res_take  = !out_valid_q || !out_stall;

	c8_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (in_valid),
		.item_busy  (busy),
		.res        (res),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.cfg_we     (cfg_valid),
		.cfg_pc     (start_address)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res_valid && res_take) out_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign read_value      = out_q.read_value;
	assign program_counter = out_q.program_counter;
	assign sound_active    = out_q.sound_active;
	assign waiting_for_key = out_q.waiting_for_key;
	assign screen_changed  = out_q.screen_changed;

`ifndef SYNTHESIS
	// a transferred item keeps the core busy in the next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core not busy after input transfer");

	// a result handed over always shows up at the output
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> out_valid)
		else $error("result lost between core and output register");

	// a key wait neither reads nor draws
	a_wait_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && waiting_for_key |-> read_value == 8'd0 && !screen_changed)
		else $error("key wait result carries read or draw data");
`endif

endmodule
